// File: rtl/core/rfsc_pkg.sv
// shared constants, types and saturation helper for the rpn stack calculator
package rfsc_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int MAG_BITS  = PROD_BITS - FRAC_BITS;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    localparam logic [2:0] MODE_PUSH = 3'd0;
    localparam logic [2:0] MODE_ADD  = 3'd1;
    localparam logic [2:0] MODE_SUB  = 3'd2;
    localparam logic [2:0] MODE_MUL  = 3'd3;
    localparam logic [2:0] MODE_DIV  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_setup;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic x_zero;
    } t_dp_sts;

    // clamp a sign and magnitude to the word range, msb of result flags saturation
    function automatic logic [WORD_BITS:0] sat_word(input logic neg,
                                                    input logic [MAG_BITS-1:0] mag);
        logic [MAG_BITS-1:0] lim;
        logic [MAG_BITS-1:0] m;
        logic                sat;
        logic [WORD_BITS-1:0] w;
        lim = neg ? (MAG_BITS'(1) << (WORD_BITS - 1))
                  : ((MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1));
        sat = 1'b0;
        m   = mag;
        if (mag > lim) begin
            m   = lim;
            sat = 1'b1;
        end
        w = neg ? (WORD_BITS'(0) - m[WORD_BITS-1:0]) : m[WORD_BITS-1:0];
        return {sat, w};
    endfunction

    function automatic logic [WORD_BITS-1:0] abs_word(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (WORD_BITS'(0) - v) : v;
    endfunction

endpackage

// File: rtl/core/rfsc_datapath.sv
// stack registers, operand magnitudes, multiplier and shift-subtract divider
module rfsc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rfsc_pkg::t_dp_cmd                    i_cmd,
    input  logic [2:0]                           i_mode,
    input  logic signed [rfsc_pkg::WORD_BITS-1:0] i_push_value,
    output rfsc_pkg::t_dp_sts                    o_sts,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_x,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_y,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_z,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_t,
    output logic [1:0]                           o_status
);
    import rfsc_pkg::*;

    logic [WORD_BITS-1:0] r_x, r_y, r_z, r_t;
    logic [WORD_BITS-1:0] n_x, n_y, n_z, n_t;
    logic [1:0]           r_status, n_status;
    logic [2:0]           r_mode;
    logic [WORD_BITS-1:0] r_push;
    logic [WORD_BITS-1:0] r_mag_x, r_mag_y;
    logic                 r_neg;
    logic [PROD_BITS-1:0] r_prod;
    logic [WORD_BITS-1:0] r_rem, r_quo;
    logic                 r_dovf;

    logic [WORD_BITS:0]   rem_sh;
    logic                 rem_ge;
    logic [WORD_BITS:0]   rem_sub;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   mul_res;
    logic [WORD_BITS:0]   div_res;
    logic [MAG_BITS-1:0]  div_mag;
    logic [FRAC_BITS-1:0] y_hi;

    assign rem_sh  = {r_rem, r_quo[WORD_BITS-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_mag_x};
    assign rem_sub = rem_sh - {1'b0, r_mag_x};
    assign y_hi    = r_mag_y[WORD_BITS-1 -: FRAC_BITS];

    assign div_mag = r_dovf ? {MAG_BITS{1'b1}}
                            : {{(MAG_BITS - WORD_BITS){1'b0}}, r_quo};
    assign mul_res = sat_word(r_neg, r_prod[PROD_BITS-1:FRAC_BITS]);
    assign div_res = sat_word(r_neg, div_mag);

    always_comb begin
        if (r_mode == MODE_SUB) begin
            sum = {r_y[WORD_BITS-1], r_y} - {r_x[WORD_BITS-1], r_x};
        end else begin
            sum = {r_y[WORD_BITS-1], r_y} + {r_x[WORD_BITS-1], r_x};
        end
    end

    always_comb begin
        n_x      = r_x;
        n_y      = r_z;
        n_z      = r_t;
        n_t      = r_t;
        n_status = ST_OK;
        case (r_mode)
            MODE_PUSH: begin
                n_x = r_push;
                n_y = r_x;
                n_z = r_y;
                n_t = r_z;
            end
            MODE_ADD, MODE_SUB: begin
                if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
                    n_x      = sum[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                              : {1'b0, {(WORD_BITS-1){1'b1}}};
                    n_status = ST_SAT;
                end else begin
                    n_x = sum[WORD_BITS-1:0];
                end
            end
            MODE_MUL: begin
                n_x = mul_res[WORD_BITS-1:0];
                if (mul_res[WORD_BITS]) begin
                    n_status = ST_SAT;
                end
            end
            MODE_DIV: begin
                if (r_x == '0) begin
                    n_x      = '0;
                    n_status = ST_DIVZERO;
                end else begin
                    n_x = div_res[WORD_BITS-1:0];
                    if (div_res[WORD_BITS]) begin
                        n_status = ST_SAT;
                    end
                end
            end
            default: begin
                n_y      = r_y;
                n_z      = r_z;
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
            r_t <= '0;
        end else if (i_cmd.commit) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_t <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_push  <= i_push_value;
            r_mag_x <= abs_word(r_x);
            r_mag_y <= abs_word(r_y);
            r_neg   <= r_x[WORD_BITS-1] ^ r_y[WORD_BITS-1];
        end
        if (i_cmd.mul_step) begin
            r_prod <= {{WORD_BITS{1'b0}}, r_mag_x} * {{WORD_BITS{1'b0}}, r_mag_y};
        end
        if (i_cmd.div_setup) begin
            r_dovf <= {{(WORD_BITS - FRAC_BITS){1'b0}}, y_hi} >= r_mag_x;
            r_rem  <= {{(WORD_BITS - FRAC_BITS){1'b0}}, y_hi};
            r_quo  <= {r_mag_y[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
            r_quo <= {r_quo[WORD_BITS-2:0], rem_ge};
        end
    end

    assign o_sts.x_zero = (r_x == '0);
    assign o_reg_x      = r_x;
    assign o_reg_y      = r_y;
    assign o_reg_z      = r_z;
    assign o_reg_t      = r_t;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_invalid_keeps_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_mode > MODE_DIV) |=>
        (r_x == $past(r_x) && r_y == $past(r_y) && r_z == $past(r_z) && r_t == $past(r_t)))
        else $error("invalid operator changed the stack");
    a_divzero_clears_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_mode == MODE_DIV && r_x == '0) |=>
        (r_x == '0 && r_status == ST_DIVZERO))
        else $error("divide by zero did not clear x");
    a_dovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> $stable(r_dovf) && $stable(r_mag_x))
        else $error("divider operands moved during iteration");
`endif

endmodule

// File: rtl/core/rfsc_ctrl.sv
// controller state machine: request intake, operation sequencing, result slot
module rfsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [2:0]          i_mode,
    input  logic                i_out_stall,
    input  rfsc_pkg::t_dp_sts   i_sts,
    output rfsc_pkg::t_dp_cmd   o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import rfsc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DSET = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_mode == MODE_MUL) begin
                        n_state = S_MUL;
                    end else if (i_mode == MODE_DIV && !i_sts.x_zero) begin
                        n_state = S_DSET;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_DONE;
            end
            S_DSET: begin
                o_cmd.div_setup = 1'b1;
                n_cnt           = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result written over a pending result");
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("request accepted but controller stayed idle");
    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_cnt == '0))
        else $error("divider count left nonzero");
`endif

endmodule

// File: rtl/core/rpn_four_level_stack_calculator_top.sv
// top level of the four-level rpn stack calculator on signed q16.16 words
//
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_mode, i_push_value
// out      output     o_out_valid / i_out_stall o_reg_x, o_reg_y, o_reg_z, o_reg_t, o_status
//
// push, add, subtract, invalid and divide by zero: go from request intake straight to the done state
// multiply: one registered 32x32 multiplier pass before the done state
// divide: a setup state, then the shift-subtract divider giving one quotient bit per cycle
// synchronous active-low reset clears the stack to zero and empties the result slot
// the result slot holds while stalled; a new request is taken, and the next result waits
module rpn_four_level_stack_calculator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [2:0]                           i_mode,
    input  logic signed [rfsc_pkg::WORD_BITS-1:0] i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_x,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_y,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_z,
    output logic signed [rfsc_pkg::WORD_BITS-1:0] o_reg_t,
    output logic [1:0]                           o_status
);
    import rfsc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rfsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rfsc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_sts        (sts),
        .o_reg_x      (o_reg_x),
        .o_reg_y      (o_reg_y),
        .o_reg_z      (o_reg_z),
        .o_reg_t      (o_reg_t),
        .o_status     (o_status)
    );

endmodule

// File: tb/rpn_four_level_stack_calculator_top_tb.sv
// self-checking testbench for the four-level rpn stack calculator
`timescale 1ns / 1ps

module rpn_four_level_stack_calculator_top_tb;
    import rfsc_pkg::*;

    localparam int WB = WORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam logic [2:0] MODE_INVALID_FIRST = 3'd5;
    localparam logic [2:0] MODE_INVALID_LAST  = 3'd7;
    localparam logic signed [WB-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [WB-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [WB-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [WB-1:0] Q_NEG_ONE = 32'shFFFF_0000;
    localparam logic signed [WB-1:0] Q_NEG_ULP = 32'shFFFF_FFFF;
    localparam int OP_TARGET   = 1700;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 50;

    typedef struct {
        logic [2:0]           mode;
        logic signed [WB-1:0] value;
        bit                   drain;
    } t_calc_token;

    typedef struct packed {
        logic signed [WB-1:0] x;
        logic signed [WB-1:0] y;
        logic signed [WB-1:0] z;
        logic signed [WB-1:0] t;
        logic [1:0]           status;
    } t_stack_view;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [2:0]           i_mode = MODE_PUSH;
    logic signed [WB-1:0] i_push_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [WB-1:0] o_reg_x;
    logic signed [WB-1:0] o_reg_y;
    logic signed [WB-1:0] o_reg_z;
    logic signed [WB-1:0] o_reg_t;
    logic [1:0]           o_status;

    t_calc_token          token_q[$];
    t_stack_view          stack_views_due[$];
    logic signed [WB-1:0] stk_x = '0;
    logic signed [WB-1:0] stk_y = '0;
    logic signed [WB-1:0] stk_z = '0;
    logic signed [WB-1:0] stk_t = '0;
    logic                 req_taken = 1'b0;
    int                   fail_cnt = 0;
    int                   cycle_cnt = 0;
    int                   burst_left = 8;
    int                   gap_left = 0;
    int                   hold_left = 0;
    int                   style_left = 0;
    int                   stall_style = 0;

    rpn_four_level_stack_calculator_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reg_x      (o_reg_x),
        .o_reg_y      (o_reg_y),
        .o_reg_z      (o_reg_z),
        .o_reg_t      (o_reg_t),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic longint signed magnitude_of(input longint signed v);
        return (v < 0) ? -v : v;
    endfunction

    // msb flags that the value had to be clamped
    function automatic logic [WB:0] clamp_word(input longint signed v);
        longint signed hi_lim;
        longint signed lo_lim;
        hi_lim = (longint'(1) <<< (WB - 1)) - 1;
        lo_lim = -(longint'(1) <<< (WB - 1));
        if (v > hi_lim) begin
            return {1'b1, hi_lim[WB-1:0]};
        end
        if (v < lo_lim) begin
            return {1'b1, lo_lim[WB-1:0]};
        end
        return {1'b0, v[WB-1:0]};
    endfunction

    function automatic t_stack_view rpn_update(input logic [2:0] mode,
                                               input logic signed [WB-1:0] value);
        t_stack_view          view;
        longint signed        ly;
        longint signed        lx;
        longint signed        mag;
        longint signed        exact;
        logic [WB:0]          clamped;
        logic signed [WB-1:0] res;
        logic                 neg;
        logic [1:0]           status;
        status = ST_OK;
        ly     = longint'(stk_y);
        lx     = longint'(stk_x);
        neg    = stk_y[WB-1] ^ stk_x[WB-1];
        exact  = 0;
        res    = '0;
        case (mode)
            MODE_PUSH: begin
                stk_t = stk_z;
                stk_z = stk_y;
                stk_y = stk_x;
                stk_x = value;
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (mode == MODE_DIV && stk_x == '0) begin
                    status = ST_DIVZERO;
                end else begin
                    case (mode)
                        MODE_ADD: exact = ly + lx;
                        MODE_SUB: exact = ly - lx;
                        MODE_MUL: begin
                            mag   = (magnitude_of(ly) * magnitude_of(lx)) >>> FB;
                            exact = neg ? -mag : mag;
                        end
                        default: begin
                            mag   = (magnitude_of(ly) <<< FB) / magnitude_of(lx);
                            exact = neg ? -mag : mag;
                        end
                    endcase
                    clamped = clamp_word(exact);
                    res     = clamped[WB-1:0];
                    if (clamped[WB]) begin
                        status = ST_SAT;
                    end
                end
                stk_x = res;
                stk_y = stk_z;
                stk_z = stk_t;
            end
            default: status = ST_INVALID;
        endcase
        view.x      = stk_x;
        view.y      = stk_y;
        view.z      = stk_z;
        view.t      = stk_t;
        view.status = status;
        return view;
    endfunction

    task automatic check_field(input string name, input logic signed [WB-1:0] want,
                               input logic signed [WB-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic add_token(input logic [2:0] mode, input logic signed [WB-1:0] value,
                             input bit drain);
        t_calc_token tok;
        tok.mode  = mode;
        tok.value = value;
        tok.drain = drain;
        token_q.push_back(tok);
    endtask

    function automatic logic signed [WB-1:0] random_push_value();
        logic signed [WB-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
            4, 5:       v = $urandom;
            6:          v = '0;
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = Q_ONE;
                    3:       v = Q_NEG_ONE;
                    default: v = Q_NEG_ULP;
                endcase
            end
            default: begin
                v = $urandom_range(0, 16'hFFFF);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    always @(negedge i_clk) begin : token_driver
        t_calc_token tok;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (token_q.size() != 0
                         && !(token_q[0].drain && stack_views_due.size() != 0)) begin
                tok = token_q.pop_front();
                i_in_valid   <= 1'b1;
                i_mode       <= tok.mode;
                i_push_value <= tok.value;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_stall_driver
        logic stall_now;
        stall_now = 1'b0;
        if (!i_rst_n) begin
            stall_now = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
        end else begin
            if (style_left <= 0) begin
                stall_style = $urandom_range(0, 2);
                style_left  = $urandom_range(20, 200);
            end
            style_left--;
            case (stall_style)
                1: begin
                    if ($urandom_range(0, 5) == 0) begin
                        stall_now = 1'b1;
                        hold_left = $urandom_range(0, 2);
                    end
                end
                2: begin
                    if ($urandom_range(0, 1) == 0) begin
                        stall_now = 1'b1;
                        hold_left = $urandom_range(0, 23);
                    end
                end
                default: stall_now = 1'b0;
            endcase
        end
        i_out_stall <= stall_now;
    end

    always @(posedge i_clk) begin : result_monitor
        t_stack_view want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                stack_views_due.push_back(rpn_update(i_mode, i_push_value));
            end
            if (o_out_valid && !i_out_stall) begin
                if (stack_views_due.size() == 0) begin
                    $error("result with no request pending");
                    fail_cnt++;
                end else begin
                    want = stack_views_due.pop_front();
                    check_field("reg_x", want.x, o_reg_x);
                    check_field("reg_y", want.y, o_reg_y);
                    check_field("reg_z", want.z, o_reg_z);
                    check_field("reg_t", want.t, o_reg_t);
                    check_field("status", WB'(want.status), WB'(o_status));
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int  op_cnt;
        int  pick;
        bit  drain;

        // saturating add and subtract, including subtracting the most negative word
        add_token(MODE_PUSH, Q_MAX, 1'b0);
        add_token(MODE_PUSH, Q_ONE, 1'b0);
        add_token(MODE_ADD, $urandom, 1'b0);
        add_token(MODE_PUSH, Q_MIN, 1'b0);
        add_token(MODE_PUSH, Q_ONE, 1'b0);
        add_token(MODE_SUB, $urandom, 1'b0);
        add_token(MODE_PUSH, '0, 1'b0);
        add_token(MODE_PUSH, Q_MIN, 1'b0);
        add_token(MODE_SUB, $urandom, 1'b0);
        // multiply truncating toward zero, then overflowing
        add_token(MODE_PUSH, Q_NEG_ULP, 1'b0);
        add_token(MODE_PUSH, 32'sh0000_8000, 1'b0);
        add_token(MODE_MUL, $urandom, 1'b0);
        add_token(MODE_PUSH, 32'sh0100_0000, 1'b0);
        add_token(MODE_PUSH, 32'sh0100_0000, 1'b0);
        add_token(MODE_MUL, $urandom, 1'b0);
        // divide by zero, truncated negative quotient, overflowing quotient, then invalid operators
        add_token(MODE_PUSH, '0, 1'b0);
        add_token(MODE_DIV, $urandom, 1'b0);
        add_token(MODE_PUSH, Q_NEG_ONE, 1'b0);
        add_token(MODE_PUSH, 32'sh0003_0000, 1'b0);
        add_token(MODE_DIV, $urandom, 1'b0);
        add_token(MODE_PUSH, Q_MIN, 1'b0);
        add_token(MODE_PUSH, Q_NEG_ONE, 1'b0);
        add_token(MODE_DIV, $urandom, 1'b0);
        add_token(MODE_INVALID_FIRST, $urandom, 1'b0);
        add_token(MODE_INVALID_FIRST + 3'd1, $urandom, 1'b0);
        add_token(MODE_INVALID_LAST, $urandom, 1'b0);

        op_cnt = 0;
        while (op_cnt < OP_TARGET) begin
            pick  = $urandom_range(0, 99);
            drain = (op_cnt == 0) || ($urandom_range(0, 199) == 0);
            if (pick < 40) begin
                add_token(MODE_PUSH, random_push_value(), drain);
                op_cnt++;
            end else if (pick < 92) begin
                add_token(3'($urandom_range(MODE_ADD, MODE_DIV)), $urandom, drain);
                op_cnt++;
            end else begin
                add_token(3'($urandom_range(MODE_INVALID_FIRST, MODE_INVALID_LAST)),
                          $urandom, drain);
                op_cnt++;
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (token_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (stack_views_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
